// File: sv/rfvp_pkg.sv
// package for the random field value picker
// holds the shared types, register and action codes, and the generator functions
// no dependencies
package rfvp_pkg;

  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  localparam logic [2:0] REG_SEED  = 3'd0;
  localparam logic [2:0] REG_CORE  = 3'd1;
  localparam logic [2:0] REG_COUNT = 3'd2;
  localparam logic [2:0] REG_SPAN  = 3'd3;
  localparam logic [2:0] REG_MODE  = 3'd4;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_DRAW   = 2'd1;
  localparam logic [1:0] ACT_RESEED = 2'd2;

  localparam int unsigned SH_A = 12;
  localparam int unsigned SH_B = 25;
  localparam int unsigned SH_C = 27;
  localparam int unsigned FOLD_SH = 16;
  localparam logic [31:0] MULT_LO = 32'h4F6C_DD1D;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 32;

  typedef struct packed {
    logic [63:0] seed;
    logic [9:0]  core_id;
    logic [8:0]  table_count;
    logic [33:0] range_span;
    logic        width_mode;
  } cfg_t;

  typedef enum logic {
    DIV_PICK,
    DIV_SPAN
  } div_sel_e;

  typedef enum logic {
    ADDR_ZERO,
    ADDR_PICK
  } addr_sel_e;

  typedef struct packed {
    logic      capture;
    logic      reseed;
    logic      seed_gen;
    logic      step_gen;
    logic      mul;
    logic      fold;
    logic      div_start;
    div_sel_e  div_sel;
    logic      pick_load;
    logic      pick_from_div;
    logic      addr_load;
    addr_sel_e addr_sel;
    logic      off_load;
    logic      off_from_div;
    logic      mem_we;
    logic      mem_re;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic seeded;
    logic n_zero;
    logic n_pow2;
    logic mag_le1;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [63:0] xsh_step(input logic [63:0] x);
    logic [63:0] a;
    logic [63:0] b;
    a = x ^ (x >> SH_A);
    b = a ^ (a << SH_B);
    return b ^ (b >> SH_C);
  endfunction

  function automatic logic [31:0] fold_word(input logic [31:0] w, input logic narrow);
    logic [31:0] r;
    r = w ^ (w >> FOLD_SH);
    return narrow ? (r & 32'h0000_FFFF) : r;
  endfunction

endpackage

// File: sv/random_field_value_picker_core.sv
// random field value picker, one item in flight: the next input transfer is taken only
// in idle, which a reseed or unused action does not leave and a load or draw returns to
// when done; the 32-step remainder unit for a count that is not a power of two, or for a
// zero count with a span magnitude above one, sets the long draws
// reset clears generator state, seeded flag and output valid at once; the table
// holds no reset value and needs no clearing pass; a waiting result stalls the next draw
module random_field_value_picker_core
  import rfvp_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] entry_index, [39:8] entry_value
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] picked_value
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rfvp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rfvp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_action_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rfvp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

// File: sv/rfvp_regs.sv
// configuration register file of the random field value picker
// apb-style write and read port, depends on rfvp_pkg
module rfvp_regs
  import rfvp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[5:3];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed        <= '0;
      cfg_q.core_id     <= '0;
      cfg_q.table_count <= '0;
      cfg_q.range_span  <= '0;
      cfg_q.width_mode  <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SEED:  cfg_q.seed        <= pwdata;
        REG_CORE:  cfg_q.core_id     <= pwdata[9:0];
        REG_COUNT: cfg_q.table_count <= pwdata[8:0];
        REG_SPAN:  cfg_q.range_span  <= pwdata[33:0];
        REG_MODE:  cfg_q.width_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEED:  prdata = cfg_q.seed;
      REG_CORE:  prdata = {54'd0, cfg_q.core_id};
      REG_COUNT: prdata = {55'd0, cfg_q.table_count};
      REG_SPAN:  prdata = {{30{cfg_q.range_span[33]}}, cfg_q.range_span};
      REG_MODE:  prdata = {63'd0, cfg_q.width_mode};
      default:   prdata = '0;
    endcase
  end

endmodule

// File: sv/rfvp_div.sv
// bit-serial restoring remainder unit, one quotient bit per cycle
// 32-bit dividend, 34-bit divisor, depends on rfvp_pkg
module rfvp_div
  import rfvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [33:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [33:0] dsr_q, dsr_d;
  logic [34:0] trial;
  logic [34:0] diff;

  assign trial  = {rem_q, dvd_q[31]};
  assign diff   = trial - {1'b0, dsr_q};
  assign done_o = done_q;
  assign rem_o  = rem_q[31:0];

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      cnt_d  = 6'd32;
      busy_d = 1'b1;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = diff[34] ? trial[33:0] : diff[33:0];
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

endmodule

// File: sv/rfvp_dp.sv
// datapath of the random field value picker: generator, multiplier, table
// memory, remainder unit and output register; depends on rfvp_pkg and rfvp_div
module rfvp_dp
  import rfvp_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [M_TDATA_W-1:0] m_tdata_o
);

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned RCP_SH = 9 + $clog2(TABLE_DEPTH);
  localparam logic [10:0] RCP_M  =
    11'(((64'd1 << RCP_SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));

  logic [63:0]      gen_q;
  logic             seeded_q;
  logic [7:0]       ent_idx_q;
  logic [31:0]      ent_val_q;
  logic [31:0]      w_q;
  logic [31:0]      r_q;
  logic [8:0]       pick_q;
  logic [IDX_W-1:0] addr_q;
  logic [31:0]      off_q;
  logic [31:0]      rd_q;
  logic [31:0]      out_data_q;
  logic             out_valid_q;
  logic [31:0]      mem_q [TABLE_DEPTH];

  logic [8:0]       n_m1;
  logic             span_neg;
  logic [33:0]      mag;
  logic [63:0]      seed_sum;
  logic [63:0]      seed_fix;
  logic [31:0]      prod;
  logic             narrow;
  logic [31:0]      fmask;
  logic [31:0]      div_dvd;
  logic [33:0]      div_dsr;
  logic             div_done;
  logic [31:0]      div_rem;
  logic [IDX_W-1:0] addr_d;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      ranged;
  logic [31:0]      result;

  // index modulo table depth by reciprocal multiplication, exact below 512
  function automatic logic [8:0] depth_rem(input logic [8:0] x);
    logic [19:0] prod_r;
    logic [8:0]  quo;
    logic [25:0] back;
    prod_r = 20'(x) * 20'(RCP_M);
    quo    = 9'(prod_r >> RCP_SH);
    back   = 26'(quo) * 26'(TABLE_DEPTH);
    return 9'(26'(x) - back);
  endfunction

  assign n_m1     = cfg_i.table_count - 9'd1;
  assign span_neg = cfg_i.range_span[33];
  assign mag      = span_neg ? (~cfg_i.range_span + 34'd1) : cfg_i.range_span;
  assign seed_sum = cfg_i.seed + 64'(cfg_i.core_id);
  assign seed_fix = (seed_sum == 64'd0) ? 64'd1 : seed_sum;
  assign prod     = gen_q[31:0] * MULT_LO;
  assign narrow   = ~cfg_i.width_mode;
  assign fmask    = narrow ? 32'h0000_FFFF : 32'hFFFF_FFFF;

  assign sts_o.seeded     = seeded_q;
  assign sts_o.n_zero     = (cfg_i.table_count == 9'd0);
  assign sts_o.n_pow2     = ((cfg_i.table_count & n_m1) == 9'd0);
  assign sts_o.mag_le1    = (mag <= 34'd1);
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = ~out_valid_q | m_tready_i;

  assign div_dvd = r_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_PICK: div_dsr = 34'(cfg_i.table_count);
      default:  div_dsr = mag;
    endcase
  end

  rfvp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign wr_addr = IDX_W'(depth_rem({1'b0, ent_idx_q}));

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_PICK: addr_d = IDX_W'(depth_rem(pick_q));
      default:   addr_d = '0;
    endcase
  end

  assign ranged = span_neg ? (rd_q - off_q) : (rd_q + off_q);
  assign result = (sts_o.n_zero ? ranged : rd_q) & fmask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.reseed) begin
        seeded_q <= 1'b0;
      end else if (cmd_i.seed_gen) begin
        seeded_q <= 1'b1;
        gen_q    <= seed_fix;
      end else if (cmd_i.step_gen) begin
        gen_q <= xsh_step(gen_q);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ent_idx_q <= s_tdata_i[7:0];
      ent_val_q <= s_tdata_i[39:8];
    end
    if (cmd_i.mul) begin
      w_q <= prod;
    end
    if (cmd_i.fold) begin
      r_q <= fold_word(w_q, narrow);
    end
    if (cmd_i.pick_load) begin
      pick_q <= cmd_i.pick_from_div ? div_rem[8:0] : (r_q[8:0] & n_m1);
    end
    if (cmd_i.addr_load) begin
      addr_q <= addr_d;
    end
    if (cmd_i.off_load) begin
      off_q <= cmd_i.off_from_div ? div_rem : 32'd0;
    end
    if (cmd_i.out_load) begin
      out_data_q <= result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[wr_addr] <= ent_val_q;
    end
    if (cmd_i.mem_re) begin
      rd_q <= mem_q[addr_q];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

// File: sv/rfvp_ctrl.sv
// controller of the random field value picker: sequences loads, reseeds and
// draws through the datapath; depends on rfvp_pkg
module rfvp_ctrl
  import rfvp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  input  logic [1:0] s_action_i,
  output logic      s_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SEED,
    ST_STEP,
    ST_MUL,
    ST_FOLD,
    ST_DECIDE,
    ST_PWAIT,
    ST_PDEPTH,
    ST_SWAIT,
    ST_READ,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i & s_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          case (s_action_i)
            ACT_LOAD:   state_d = ST_WRITE;
            ACT_DRAW:   state_d = sts_i.seeded ? ST_STEP : ST_SEED;
            ACT_RESEED: cmd_o.reseed = 1'b1;
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        cmd_o.mem_we = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SEED: begin
        cmd_o.seed_gen = 1'b1;
        state_d        = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step_gen = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.n_zero) begin
          if (sts_i.mag_le1) begin
            cmd_o.off_load  = 1'b1;
            cmd_o.addr_load = 1'b1;
            cmd_o.addr_sel  = ADDR_ZERO;
            state_d         = ST_READ;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_SPAN;
            state_d         = ST_SWAIT;
          end
        end else if (sts_i.n_pow2) begin
          cmd_o.pick_load = 1'b1;
          state_d         = ST_PDEPTH;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_PICK;
          state_d         = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.pick_load     = 1'b1;
          cmd_o.pick_from_div = 1'b1;
          state_d             = ST_PDEPTH;
        end
      end
      ST_PDEPTH: begin
        cmd_o.addr_load = 1'b1;
        cmd_o.addr_sel  = ADDR_PICK;
        state_d         = ST_READ;
      end
      ST_SWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.off_load     = 1'b1;
          cmd_o.off_from_div = 1'b1;
          cmd_o.addr_load    = 1'b1;
          cmd_o.addr_sel     = ADDR_ZERO;
          state_d            = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.mem_re = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/rfvp_checker.sv
// port-level checks for the random field value picker
// bound to random_field_value_picker_core, depends on rfvp_pkg
module rfvp_checker
  import rfvp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [1:0]           s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // a result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // a draw keeps the input side busy for the following cycle
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_DRAW |=> !s_axis_tready)
    else $error("input taken during a draw");

  // no result appears right after a non-draw transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != ACT_DRAW |=> !$rose(m_axis_tvalid))
    else $error("result raised without a draw");

  // a result only rises while the input side is busy with its draw
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised outside a draw");

endmodule

bind random_field_value_picker_core rfvp_checker u_rfvp_checker (.*);

// File: tb/sv/tb_random_field_value_picker_core.sv
// self-checking testbench for random_field_value_picker_core, depends on rfvp_pkg
// and the core only; a directed table, then randomised phases of loads, draws,
// reseeds and unused actions; draws checked against typed values or a generator copy
module tb_random_field_value_picker_core;
  import rfvp_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         PLAN_LEN     = 36;
  localparam int         PHASES       = 24;
  localparam int         PHASE_ITEMS  = 64;
  localparam int         DRAIN_CYCLES = 100;
  localparam int         LIMIT_CYCLES = 1_000_000;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_sel;
    logic [63:0] wdata;
    logic [1:0]  action;
    logic [7:0]  idx;
    logic [31:0] val;
    logic        typed;
    logic [31:0] typed_val;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [7:0] entry_index, [39:8] entry_value
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // [1:0] action
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [31:0] picked_value
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // generator copy and register shadows
  logic [63:0] cfg_seed  = 64'd0;
  logic [9:0]  cfg_core  = 10'd0;
  logic [8:0]  cfg_count = 9'd0;
  logic [33:0] cfg_span  = 34'd0;
  logic        cfg_mode  = 1'b1;
  logic [63:0] gen_state = 64'd0;
  logic        gen_seeded = 1'b0;
  logic [31:0] entry_store [256];
  bit          entry_loaded [256];

  logic [31:0] picked_q [$];
  logic        pick_typed = 1'b0;
  logic [31:0] pick_typed_val = 32'd0;
  bit          feed_burst = 1'b0;
  bit          drain_burst = 1'b0;
  int          err_count = 0;
  int          cycle_count = 0;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_LOAD,   8'd0,   32'hFFFF_FFFF,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b1, 32'hFFFF_FFFF},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_LOAD,   8'd255, 32'h5A5A_A5A5,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_UNUSED, 8'd255, 32'hFFFF_FFFF,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_RESEED, 8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b1, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_LOAD,   8'd0,   32'hABCD_1234,
      1'b0, 32'd0},
    '{ROW_CFG,  REG_MODE,  64'd0,                  ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b1, 32'h0000_1234},
    '{ROW_CFG,  REG_SPAN,  64'hFFFF_FFFF_FFFF_FFFF, ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b1, 32'h0000_1234},
    '{ROW_CFG,  REG_MODE,  64'd1,                  ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b1, 32'hABCD_1234},
    '{ROW_CFG,  REG_SPAN,  64'd1,                  ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b1, 32'hABCD_1234},
    '{ROW_CFG,  REG_SPAN,  64'h0000_0001_0000_0000, ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_CFG,  REG_SPAN,  64'hFFFF_FFFF_0000_0000, ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_CFG,  REG_COUNT, 64'd1,                  ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b1, 32'hABCD_1234},
    '{ROW_CFG,  REG_COUNT, 64'd3,                  ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_LOAD,   8'd1,   32'h0000_0001,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_LOAD,   8'd2,   32'h8000_0000,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_CFG,  REG_SEED,  64'hFFFF_FFFF_FFFF_FFFF, ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_CFG,  REG_CORE,  64'd1,                  ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_RESEED, 8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_CFG,  REG_CORE,  64'd1023,               ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_CFG,  REG_COUNT, 64'd0,                  ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_CFG,  REG_SPAN,  64'hFFFF_FFFF_FFFF_FFFB, ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_CFG,  REG_MODE,  64'd0,                  ACT_LOAD,   8'd0,   32'd0,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_LOAD,   8'd0,   32'h0000_0002,
      1'b0, 32'd0},
    '{ROW_ITEM, REG_SEED,  64'd0,                  ACT_DRAW,   8'd0,   32'd0,
      1'b0, 32'd0}
  };

  random_field_value_picker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] predict_pick();
    logic [63:0] x;
    logic [63:0] prod;
    logic [31:0] w;
    logic [31:0] r;
    logic [31:0] fmask;
    logic [31:0] pos;
    logic [31:0] n;
    logic [31:0] base;
    logic [33:0] mag;
    logic [33:0] off;
    if (!gen_seeded) begin
      gen_state = cfg_seed + {54'd0, cfg_core};
      if (gen_state == 64'd0) gen_state = 64'd1;
      gen_seeded = 1'b1;
    end
    x = gen_state;
    x = x ^ (x >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    gen_state = x;
    prod = x * 64'h2545_F491_4F6C_DD1D;
    w = prod[31:0];
    fmask = cfg_mode ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    r = (w ^ (w >> 16)) & fmask;
    n = {23'd0, cfg_count};
    if (n != 32'd0) begin
      pos = ((n & (n - 32'd1)) == 32'd0) ? (r & (n - 32'd1)) : (r % n);
      return entry_store[pos[7:0]] & fmask;
    end
    base = entry_store[0];
    mag = cfg_span[33] ? (~cfg_span + 34'd1) : cfg_span;
    if (mag <= 34'd1) return base & fmask;
    off = {2'b00, r} % mag;
    return (cfg_span[33] ? (base - off[31:0]) : (base + off[31:0])) & fmask;
  endfunction

  // first slot that a draw could reach but that holds nothing yet, or -1
  function automatic int first_gap();
    int reach;
    reach = (cfg_count == 9'd0) ? 1 : ((cfg_count > 9'd256) ? 256 : int'(cfg_count));
    for (int i = 0; i < reach; i++) begin
      if (!entry_loaded[i]) return i;
    end
    return -1;
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [7:0] idx,
                           input logic [31:0] val, input logic typed,
                           input logic [31:0] typed_val);
    int gap;
    if ($urandom_range(0, 63) == 0) feed_burst = !feed_burst;
    gap = feed_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {val, idx};
    pick_typed = typed;
    pick_typed_val = typed_val;
    if (act == ACT_LOAD) entry_loaded[idx] = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] sel, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_SEED:  cfg_seed = data;
      REG_CORE:  cfg_core = data[9:0];
      REG_COUNT: cfg_count = data[8:0];
      REG_SPAN:  cfg_span = data[33:0];
      REG_MODE:  cfg_mode = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait for every pick to arrive, then let a trailing load finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (picked_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : watch
    logic [31:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (picked_q.size() == 0) begin
          $error("picked_value transfer with nothing pending, actual %h", m_axis_tdata);
          err_count++;
        end else begin
          want = picked_q.pop_front();
          if (m_axis_tdata !== want) begin
            $error("picked_value: expected %h, actual %h", want, m_axis_tdata);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          ACT_LOAD:   entry_store[s_axis_tdata[7:0]] = s_axis_tdata[39:8];
          ACT_DRAW: begin
            want = predict_pick();
            picked_q.push_back(pick_typed ? pick_typed_val : want);
          end
          ACT_RESEED: gen_seeded = 1'b0;
          default: ;
        endcase
      end
    end
  end

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) drain_burst = !drain_burst;
      stall = drain_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin
    int          done_items;
    int          k;
    int          hole;
    logic [1:0]  act;
    logic [7:0]  idx;
    logic [31:0] val;
    logic [63:0] seed_v;
    logic [9:0]  core_v;
    logic [8:0]  count_v;
    logic [33:0] span_v;
    logic [33:0] mag_v;
    logic [8:0]  count_list [16];
    count_list = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd5, 9'd7, 9'd16, 9'd100,
                   9'd128, 9'd200, 9'd255, 9'd256, 9'd257, 9'd300, 9'd511, 9'd0};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_LOAD;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].wdata);
      end else begin
        send_item(plan[i].action, plan[i].idx, plan[i].val, plan[i].typed,
                  plan[i].typed_val);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 3)
        0:       seed_v = 64'd0;
        1:       seed_v = 64'hFFFF_FFFF_FFFF_FFFF;
        default: seed_v = {$urandom(), $urandom()};
      endcase
      case (p % 4)
        0:       core_v = 10'd0;
        1:       core_v = 10'd1023;
        2:       core_v = 10'd1;
        default: core_v = 10'($urandom_range(0, 1023));
      endcase
      count_v = (p < 16) ? count_list[p] :
                (($urandom_range(0, 3) == 0) ? 9'd0 : 9'($urandom_range(0, 511)));
      case ($urandom_range(0, 7))
        0:       span_v = 34'd0;
        1:       span_v = 34'd1;
        2:       span_v = 34'h3_FFFF_FFFF;
        3:       span_v = 34'h1_0000_0000;
        4:       span_v = 34'h3_0000_0000;
        5:       span_v = 34'($urandom_range(2, 300));
        6:       span_v = ~34'($urandom_range(2, 300)) + 34'd1;
        default: begin
          mag_v = {2'b00, $urandom()};
          span_v = $urandom_range(0, 1) ? (~mag_v + 34'd1) : mag_v;
        end
      endcase
      write_reg(REG_SEED, seed_v);
      write_reg(REG_CORE, {54'd0, core_v});
      write_reg(REG_COUNT, {55'd0, count_v});
      write_reg(REG_SPAN, {{30{span_v[33]}}, span_v});
      write_reg(REG_MODE, (p < 16) ? 64'(p % 2) : 64'($urandom_range(0, 1)));

      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        k = $urandom_range(0, 99);
        idx = 8'($urandom_range(0, 255));
        val = $urandom();
        hole = first_gap();
        if (k < 8) begin
          act = ACT_UNUSED;
        end else if (k < 15) begin
          act = ACT_RESEED;
        end else if (k < 55) begin
          act = ACT_LOAD;
          if (hole >= 0 && $urandom_range(0, 1) == 1) idx = hole[7:0];
        end else begin
          act = ACT_DRAW;
          // a draw must never reach an empty slot, so a load fills it instead
          if (hole >= 0) begin
            act = ACT_LOAD;
            idx = hole[7:0];
          end
        end
        send_item(act, idx, val, 1'b0, 32'd0);
        done_items++;
      end
    end

    settle();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rfvp_pkg.sv
sv/rfvp_regs.sv
sv/rfvp_div.sv
sv/rfvp_dp.sv
sv/rfvp_ctrl.sv
sv/random_field_value_picker_core.sv
sv/rfvp_checker.sv
tb/sv/tb_random_field_value_picker_core.sv
